### hw/rtl/gdh_pkg.sv
// gdh_pkg: shared types, constants and tables for the gaussian density heat-map pixel block
// used by gdh_div and gaussian_density_heatmap_pixel; no dependencies
package gdh_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CX_SHIFT   = 6;
    localparam int HIT_LIM    = 64;
    localparam int EXP_LIMIT  = 12;
    localparam int SERIES_N   = 10;
    localparam int DIV_W      = 54;
    localparam int DEN_W      = 45;
    localparam int ACC_W      = 41;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_RENDER = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_PT,
        S_SQY,
        S_D2,
        S_ARG,
        S_MA,
        S_MB,
        S_MC,
        S_EXP,
        S_ACC,
        S_AVG,
        S_AVGW,
        S_V,
        S_P,
        S_LV,
        S_LVW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quo;
    } t_div_rsp;

    typedef logic [30:0] t_exp_tab [0:EXP_LIMIT-1];
    typedef logic [20:0] t_norm_tab [0:2];

    // e^-n in q1.30, repeated rounded multiply by e^-1
    function automatic t_exp_tab f_exp_tab();
        t_exp_tab        tab;
        longint unsigned v;
        v = 64'd1 << 30;
        for (int n = 0; n < EXP_LIMIT; n++) begin
            tab[n] = v[30:0];
            v = (v * 64'd395007542 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam t_exp_tab  EXP_TAB  = f_exp_tab();
    localparam t_norm_tab NORM_TAB = '{21'd209161, 21'd591596, 21'd1673285};

    // floor((2^32-1)/k) for the series divisors
    function automatic logic [31:0] f_recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/gdh_div.sv
// gdh_div: restoring divider, one quotient bit per cycle
// depends on gdh_pkg for widths and the request and response structs
module gdh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdh_pkg::t_div_req i_req,
    output gdh_pkg::t_div_rsp o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [5:0]                 r_cnt;
    logic [gdh_pkg::DEN_W-1:0]  r_rem;
    logic [gdh_pkg::DEN_W-1:0]  r_den;
    logic [gdh_pkg::DIV_W-1:0]  r_quo;
    logic [gdh_pkg::DEN_W:0]    rem_sh;
    logic [gdh_pkg::DEN_W:0]    rem_sub;
    logic                       ge;

    assign rem_sh  = {r_rem, r_quo[gdh_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(gdh_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[gdh_pkg::DEN_W-1:0] : rem_sh[gdh_pkg::DEN_W-1:0];
            r_quo <= {r_quo[gdh_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### hw/rtl/gaussian_density_heatmap_pixel.sv
// gaussian_density_heatmap_pixel: point store and per-pixel three-width kernel density render
// depends on gdh_pkg and gdh_div
//
//  channel | handshake             | words
//  in      | i_in_valid/o_in_stall | i_op, i_point_x, i_point_y, i_pixel_x, i_pixel_y
//  out     | o_out_valid/i_out_stall | o_red_level, o_green_level, o_blue_level, o_store_full
//
// clear and load are answered straight from idle; a render of an empty store is answered the same way
// a render walks every stored point and then makes the six divides and the soft clip; its length
// is set by the shared 32x32 multiplier and the series steps
// the input is stalled while a render runs or while a held result is stalled
// reset is synchronous; the point store needs no clearing, only the count is reset
module gaussian_density_heatmap_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic [8:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic        o_store_full
);

    gdh_pkg::t_state r_state, n_state;

    logic [31:0]                 r_mem [0:gdh_pkg::MAX_POINTS-1];
    logic [31:0]                 r_rd;
    logic [gdh_pkg::CNT_W-1:0]   r_count;
    logic [gdh_pkg::CNT_W-1:0]   r_idx;
    logic [15:0]                 r_cx, r_cy, r_ay;
    logic                        r_hit;
    logic [32:0]                 r_d2;
    logic [1:0]                  r_c;
    logic [3:0]                  r_n;
    logic [15:0]                 r_f;
    logic [30:0]                 r_term, r_sum;
    logic [3:0]                  r_k;
    logic [29:0]                 r_x;
    logic [gdh_pkg::ACC_W-1:0]   r_acc [0:2];
    logic [20:0]                 r_v;
    logic [7:0]                  r_lvl [0:2];
    logic [63:0]                 r_prod;
    logic                        r_ovalid;
    logic [7:0]                  r_red, r_green, r_blue;
    logic                        r_full;

    logic                        acc;
    logic                        full;
    logic                        last_pt;
    logic [15:0]                 ptx, pty, ax, ay;
    logic [28:0]                 t_arg;
    logic                        over;
    logic [29:0]                 q_est;
    logic [33:0]                 qk, rem_k;
    logic [30:0]                 term_nx;
    logic [61:0]                 kern_full;
    logic [31:0]                 kern;
    logic [43:0]                 p_val;
    logic [gdh_pkg::DEN_W-1:0]   den_val;
    logic [gdh_pkg::DIV_W-1:0]   num_val;
    logic [22:0]                 p_a;
    logic [31:0]                 mul_a, mul_b;
    logic                        out_free;
    logic                        imm_load, emit_load;
    logic [7:0]                  o_r_nx, o_g_nx, o_b_nx;
    logic                        o_f_nx;
    gdh_pkg::t_div_req           div_req;
    gdh_pkg::t_div_rsp           div_rsp;

    gdh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // point arithmetic
    assign full     = r_count == gdh_pkg::CNT_W'(gdh_pkg::MAX_POINTS);
    assign last_pt  = (r_idx + 1'b1) == r_count;
    assign ptx      = r_rd[15:0];
    assign pty      = r_rd[31:16];
    assign ax       = (r_cx > ptx) ? r_cx - ptx : ptx - r_cx;
    assign ay       = (r_cy > pty) ? r_cy - pty : pty - r_cy;

    always_comb begin
        case (r_c)
            2'd0:    t_arg = 29'(r_d2[32:10]);
            2'd1:    t_arg = 29'(r_d2[32:7]);
            default: t_arg = r_d2[32:4];
        endcase
    end

    assign over      = t_arg >= 29'(gdh_pkg::EXP_LIMIT << 16);
    assign q_est     = r_prod[61:32];
    assign qk        = 34'(q_est) * 34'(r_k);
    assign rem_k     = 34'(r_x) - qk;
    assign term_nx   = 31'(q_est) + 31'(rem_k >= 34'(r_k));
    assign kern_full = r_prod[61:0] + (62'd1 << 29);
    assign kern      = kern_full[61:30];
    assign p_a       = 23'(r_v) + 23'({r_v, 1'b0}) + 23'd65536;
    assign p_val     = r_prod[43:0];
    assign den_val   = 45'(p_val) + (45'd1 << 32);
    assign num_val   = 54'({p_val, 8'b0}) - 54'(p_val) + 54'(den_val[gdh_pkg::DEN_W-1:1]);

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gdh_pkg::S_IDLE: begin
                if (acc && i_op == gdh_pkg::OP_RENDER && r_count != '0) n_state = gdh_pkg::S_RD;
            end
            gdh_pkg::S_RD:  n_state = gdh_pkg::S_PT;
            gdh_pkg::S_PT:  n_state = gdh_pkg::S_SQY;
            gdh_pkg::S_SQY: n_state = gdh_pkg::S_D2;
            gdh_pkg::S_D2:  n_state = gdh_pkg::S_ARG;
            gdh_pkg::S_ARG: begin
                if (!over) n_state = gdh_pkg::S_MA;
                else if (r_c != 2'd2) n_state = gdh_pkg::S_ARG;
                else n_state = last_pt ? gdh_pkg::S_AVG : gdh_pkg::S_RD;
            end
            gdh_pkg::S_MA:  n_state = gdh_pkg::S_MB;
            gdh_pkg::S_MB:  n_state = gdh_pkg::S_MC;
            gdh_pkg::S_MC:  n_state = (r_k == 4'(gdh_pkg::SERIES_N)) ? gdh_pkg::S_EXP
                                                                     : gdh_pkg::S_MA;
            gdh_pkg::S_EXP: n_state = gdh_pkg::S_ACC;
            gdh_pkg::S_ACC: begin
                if (r_c != 2'd2) n_state = gdh_pkg::S_ARG;
                else n_state = last_pt ? gdh_pkg::S_AVG : gdh_pkg::S_RD;
            end
            gdh_pkg::S_AVG:  n_state = gdh_pkg::S_AVGW;
            gdh_pkg::S_AVGW: if (div_rsp.done) n_state = gdh_pkg::S_V;
            gdh_pkg::S_V:    n_state = gdh_pkg::S_P;
            gdh_pkg::S_P:    n_state = gdh_pkg::S_LV;
            gdh_pkg::S_LV:   n_state = gdh_pkg::S_LVW;
            gdh_pkg::S_LVW: begin
                if (div_rsp.done) n_state = (r_c == 2'd2) ? gdh_pkg::S_EMIT : gdh_pkg::S_AVG;
            end
            gdh_pkg::S_EMIT: if (out_free) n_state = gdh_pkg::S_IDLE;
            default:         n_state = gdh_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_free    = !(r_ovalid && i_out_stall);
        o_in_stall  = (r_state != gdh_pkg::S_IDLE) || !out_free;
        acc         = i_in_valid && !o_in_stall;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        imm_load    = 1'b0;
        emit_load   = 1'b0;
        o_r_nx      = '0;
        o_g_nx      = '0;
        o_b_nx      = '0;
        o_f_nx      = full;
        case (r_state)
            gdh_pkg::S_IDLE: begin
                if (acc) begin
                    case (i_op)
                        gdh_pkg::OP_CLEAR: begin
                            imm_load = 1'b1;
                            o_f_nx   = 1'b0;
                        end
                        gdh_pkg::OP_LOAD: begin
                            imm_load = 1'b1;
                            o_f_nx   = full || ((r_count + 1'b1) ==
                                                gdh_pkg::CNT_W'(gdh_pkg::MAX_POINTS));
                        end
                        gdh_pkg::OP_RENDER: imm_load = r_count == '0;
                        default:            imm_load = 1'b0;
                    endcase
                end
            end
            gdh_pkg::S_PT: begin
                mul_a = 32'(ax);
                mul_b = 32'(ax);
            end
            gdh_pkg::S_SQY: begin
                mul_a = 32'(r_ay);
                mul_b = 32'(r_ay);
            end
            gdh_pkg::S_MA: begin
                mul_a = 32'(r_term);
                mul_b = 32'(r_f);
            end
            gdh_pkg::S_MB: begin
                mul_a = 32'(r_prod[45:16]);
                mul_b = gdh_pkg::f_recip(r_k);
            end
            gdh_pkg::S_EXP: begin
                mul_a = 32'(gdh_pkg::EXP_TAB[r_n]);
                mul_b = 32'(r_sum);
            end
            gdh_pkg::S_AVG: begin
                div_req.start = 1'b1;
                div_req.num   = gdh_pkg::DIV_W'(r_acc[r_c]);
                div_req.den   = gdh_pkg::DEN_W'(r_count);
            end
            gdh_pkg::S_AVGW: begin
                mul_a = div_rsp.quo[31:0];
                mul_b = 32'(gdh_pkg::NORM_TAB[r_c]);
            end
            gdh_pkg::S_P: begin
                mul_a = 32'(p_a);
                mul_b = 32'(r_v);
            end
            gdh_pkg::S_LV: begin
                div_req.start = 1'b1;
                div_req.num   = num_val;
                div_req.den   = den_val;
            end
            gdh_pkg::S_EMIT: begin
                emit_load = out_free;
                o_r_nx    = r_lvl[0];
                o_g_nx    = r_lvl[1];
                o_b_nx    = r_hit ? 8'hFF : r_lvl[2];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (r_state == gdh_pkg::S_IDLE && acc && i_op == gdh_pkg::OP_LOAD && !full) begin
            r_mem[r_count[gdh_pkg::ADDR_W-1:0]] <= {i_point_y, i_point_x};
        end
        r_rd <= r_mem[r_idx[gdh_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == gdh_pkg::S_IDLE && acc) begin
            if (i_op == gdh_pkg::OP_CLEAR) r_count <= '0;
            else if (i_op == gdh_pkg::OP_LOAD && !full) r_count <= r_count + 1'b1;
        end
    end

    // render datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            gdh_pkg::S_IDLE: begin
                r_cx  <= 16'({i_pixel_x, 1'b1} << gdh_pkg::CX_SHIFT);
                r_cy  <= 16'({i_pixel_y, 1'b1} << gdh_pkg::CX_SHIFT);
                r_idx <= '0;
                r_hit <= 1'b0;
                r_c   <= '0;
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end
            gdh_pkg::S_PT: begin
                r_ay <= ay;
                if (ax < 16'(gdh_pkg::HIT_LIM) && ay < 16'(gdh_pkg::HIT_LIM)) r_hit <= 1'b1;
            end
            gdh_pkg::S_SQY: r_d2 <= {1'b0, r_prod[31:0]};
            gdh_pkg::S_D2: begin
                r_d2 <= r_d2 + 33'(r_prod[31:0]);
                r_c  <= '0;
            end
            gdh_pkg::S_ARG: begin
                r_n    <= t_arg[19:16];
                r_f    <= t_arg[15:0];
                r_term <= 31'd1 << 30;
                r_sum  <= 31'd1 << 30;
                r_k    <= 4'd1;
                if (over) begin
                    if (r_c != 2'd2) r_c <= r_c + 2'd1;
                    else begin
                        r_c   <= '0;
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            gdh_pkg::S_MB: r_x <= r_prod[45:16];
            gdh_pkg::S_MC: begin
                r_term <= term_nx;
                r_sum  <= r_k[0] ? r_sum - term_nx : r_sum + term_nx;
                r_k    <= r_k + 4'd1;
            end
            gdh_pkg::S_ACC: begin
                r_acc[r_c] <= r_acc[r_c] + gdh_pkg::ACC_W'(kern);
                if (r_c != 2'd2) r_c <= r_c + 2'd1;
                else begin
                    r_c   <= '0;
                    r_idx <= r_idx + 1'b1;
                end
            end
            gdh_pkg::S_V: r_v <= r_prod[50:30];
            gdh_pkg::S_LVW: begin
                if (div_rsp.done) begin
                    r_lvl[r_c] <= div_rsp.quo[7:0];
                    if (r_c != 2'd2) r_c <= r_c + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (imm_load || emit_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (imm_load || emit_load) begin
            r_red   <= o_r_nx;
            r_green <= o_g_nx;
            r_blue  <= o_b_nx;
            r_full  <= o_f_nx;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;
    assign o_store_full  = r_full;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gdh_pkg::CNT_W'(gdh_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == gdh_pkg::S_AVGW || r_state == gdh_pkg::S_LVW))
        else $error("divider finished outside a wait state");

    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdh_pkg::S_IDLE && acc && i_op == gdh_pkg::OP_RENDER && r_count != '0)
        |=> r_state == gdh_pkg::S_RD)
        else $error("render of a filled store did not start");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdh_pkg::S_EMIT && out_free)
        |=> (o_out_valid && r_state == gdh_pkg::S_IDLE))
        else $error("render result not presented");

    a_series_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gdh_pkg::S_MA |-> (r_k >= 4'd1 && r_k <= 4'(gdh_pkg::SERIES_N)))
        else $error("series step out of range");
`endif

endmodule

### tb/gaussian_density_heatmap_pixel_tb.sv
// gaussian_density_heatmap_pixel_tb: self-checking bench for the kernel density pixel block
// drives clear/load/render words with random gaps and checks colours and the full flag against a local model
// depends on gdh_pkg and the gaussian_density_heatmap_pixel rtl
`timescale 1ns / 1ps

module gaussian_density_heatmap_pixel_tb;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int         LIMIT_CYCLES = 3000000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] px;
        logic [15:0] py;
        logic [8:0]  cx;
        logic [8:0]  cy;
        bit          drain;
    } t_word;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       full;
    } t_levels;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [15:0] i_point_x = '0;
    logic [15:0] i_point_y = '0;
    logic [8:0]  i_pixel_x = '0;
    logic [8:0]  i_pixel_y = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_red_level;
    logic [7:0]  o_green_level;
    logic [7:0]  o_blue_level;
    logic        o_store_full;

    gaussian_density_heatmap_pixel DUT (.*);

    always #5 i_clk = ~i_clk;

    t_word           word_q[$];
    t_levels         level_q[$];
    longint unsigned exp_int[gdh_pkg::EXP_LIMIT];
    logic [15:0]     store_x[gdh_pkg::MAX_POINTS];
    logic [15:0]     store_y[gdh_pkg::MAX_POINTS];
    int              store_cnt;
    bit              calm = 1'b0;
    bit              rst_done = 1'b0;
    bit              in_acc = 1'b0;
    bit              out_acc = 1'b0;
    int              gap = 0;
    int              stall_left = 0;
    int              errors = 0;
    int              n_render = 0;
    int              n_load = 0;
    int              n_hit = 0;
    int              n_full = 0;
    int              n_out = 0;
    longint          cycles = 0;

    function automatic longint unsigned neg_exp_q30(longint unsigned t);
        longint unsigned n, f, term;
        longint          acc;
        if (t >= (longint'(gdh_pkg::EXP_LIMIT) << 16)) return 0;
        n = t >> 16;
        f = t & 64'hFFFF;
        term = 64'd1 << 30;
        acc = 64'd1 << 30;
        for (int k = 1; k <= gdh_pkg::SERIES_N; k++) begin
            term = (term * f) / (longint'(k) << 16);
            if (k & 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return (exp_int[n] * longint'(acc) + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [7:0] soft_level(longint unsigned v);
        longint unsigned p, den;
        p = (3 * v + 65536) * v;
        den = p + (64'd1 << 32);
        return 8'((255 * p + den / 2) / den);
    endfunction

    function automatic longint unsigned centre(logic [8:0] p);
        return ((2 * longint'(p) + 1) << 16) / 1024;
    endfunction

    function automatic t_levels render_pixel(logic [8:0] pxi, logic [8:0] pyi);
        t_levels         res;
        longint unsigned cx, cy, ax, ay, d2, avg, v;
        longint unsigned sums[3];
        longint unsigned norm[3];
        int              shifts[3];
        bit              hit;
        norm = '{64'd209161, 64'd591596, 64'd1673285};
        shifts = '{6, 9, 12};
        sums = '{0, 0, 0};
        hit = 1'b0;
        res = '{default: '0};
        if (store_cnt == 0) return res;
        cx = centre(pxi);
        cy = centre(pyi);
        for (int i = 0; i < store_cnt; i++) begin
            ax = cx > store_x[i] ? cx - store_x[i] : store_x[i] - cx;
            ay = cy > store_y[i] ? cy - store_y[i] : store_y[i] - cy;
            if (ax * 1024 < 65536 && ay * 1024 < 65536) hit = 1'b1;
            if (ax > (64'd1 << 18)) ax = 64'd1 << 18;
            if (ay > (64'd1 << 18)) ay = 64'd1 << 18;
            d2 = ax * ax + ay * ay;
            for (int c = 0; c < 3; c++) sums[c] += neg_exp_q30(d2 >> (16 - shifts[c]));
        end
        for (int c = 0; c < 3; c++) begin
            avg = sums[c] / store_cnt;
            v = (avg * norm[c]) >> 30;
            sums[c] = soft_level(v);
        end
        res.r = sums[0][7:0];
        res.g = sums[1][7:0];
        res.b = hit ? 8'd255 : sums[2][7:0];
        if (hit) n_hit++;
        return res;
    endfunction

    function automatic void predict_word();
        t_levels res;
        res = '{default: '0};
        case (i_op)
            gdh_pkg::OP_CLEAR: store_cnt = 0;
            gdh_pkg::OP_LOAD: begin
                n_load++;
                if (store_cnt < gdh_pkg::MAX_POINTS) begin
                    store_x[store_cnt] = i_point_x;
                    store_y[store_cnt] = i_point_y;
                    store_cnt++;
                end
            end
            gdh_pkg::OP_RENDER: begin
                n_render++;
                if (store_cnt == gdh_pkg::MAX_POINTS) n_full++;
                res = render_pixel(i_pixel_x, i_pixel_y);
            end
            default: return;
        endcase
        res.full = (store_cnt >= gdh_pkg::MAX_POINTS);
        level_q.push_back(res);
    endfunction

    // monitor, checker and predictor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
        in_acc <= i_in_valid && !o_in_stall;
        out_acc <= o_out_valid && !i_out_stall;
        if (rst_done && o_out_valid && !i_out_stall) begin
            n_out++;
            if (level_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
            end else begin
                t_levels e;
                e = level_q.pop_front();
                if (e.r !== o_red_level || e.g !== o_green_level || e.b !== o_blue_level
                    || e.full !== o_store_full) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp r%0d g%0d b%0d f%0d got r%0d g%0d b%0d f%0d",
                            e.r, e.g, e.b, e.full, o_red_level, o_green_level,
                            o_blue_level, o_store_full);
                end
            end
        end
        if (rst_done && i_in_valid && !o_in_stall) predict_word();
    end

    // input driver
    always @(negedge i_clk) begin
        if (rst_done && !(i_in_valid && !in_acc)) begin
            if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else if (word_q.size() > 0 && !(word_q[0].drain && level_q.size() > 0)) begin
                t_word w;
                w = word_q.pop_front();
                i_op <= w.op;
                i_point_x <= w.px;
                i_point_y <= w.py;
                i_pixel_x <= w.cx;
                i_pixel_y <= w.cy;
                i_in_valid <= 1'b1;
                gap = calm ? 0 : $urandom_range(0, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (out_acc) stall_left = calm ? 0 : $urandom_range(0, 7);
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void add_word(logic [1:0] op, logic [15:0] px = '0, logic [15:0] py = '0,
                                     logic [8:0] cx = '0, logic [8:0] cy = '0, bit drain = 0);
        t_word w;
        w = '{op, px, py, cx, cy, drain};
        word_q.push_back(w);
    endfunction

    function automatic void add_render(logic [8:0] cx, logic [8:0] cy);
        add_word(gdh_pkg::OP_RENDER, 16'($urandom), 16'($urandom), cx, cy);
    endfunction

    initial begin
        logic [8:0]  hx, hy;
        logic [15:0] ox, oy;
        exp_int[0] = 64'd1 << 30;
        for (int n = 1; n < gdh_pkg::EXP_LIMIT; n++)
            exp_int[n] = (exp_int[n-1] * 64'd395007542 + (64'd1 << 29)) >> 30;
        store_cnt = 0;

        // directed
        add_word(gdh_pkg::OP_RENDER, 16'hFFFF, 16'hFFFF, 9'd0, 9'd0);
        add_word(gdh_pkg::OP_LOAD, 16'h0000, 16'h0000);
        add_render(9'd0, 9'd0);
        add_render(9'd511, 9'd511);
        add_word(gdh_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF);
        add_word(gdh_pkg::OP_LOAD, 16'h0000, 16'hFFFF);
        add_word(gdh_pkg::OP_LOAD, 16'hFFFF, 16'h0000);
        add_render(9'd511, 9'd511);
        add_render(9'd0, 9'd511);
        add_word(OP_NONE, 16'($urandom), 16'($urandom), 9'($urandom), 9'($urandom));
        add_word(gdh_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF);
        add_word(gdh_pkg::OP_LOAD, 16'(centre(9'd10)), 16'(centre(9'd20)));
        add_render(9'd10, 9'd20);
        add_render(9'd11, 9'd20);
        add_render(9'd256, 9'd256);
        add_word(gdh_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b1);
        add_render(9'd5, 9'd5);

        // fill the store, then overflow it
        for (int i = 0; i < gdh_pkg::MAX_POINTS + 2; i++)
            add_word(gdh_pkg::OP_LOAD, 16'($urandom), 16'($urandom));
        add_render(9'($urandom), 9'($urandom));
        add_word(gdh_pkg::OP_CLEAR);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1'b1;

        // random sequences: clear, one to eight loads, one to four renders
        for (int seq = 0; seq < 70; seq++) begin
            int nl;
            if (seq % 10 == 0) calm = ~calm;
            nl = $urandom_range(1, 8);
            add_word(gdh_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 9'($urandom), 9'($urandom),
                     seq % 15 == 7);
            hx = 9'($urandom);
            hy = 9'($urandom);
            for (int i = 0; i < nl; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    ox = 16'(centre(hx)) + 16'($urandom_range(0, 120)) - 16'd60;
                    oy = 16'(centre(hy)) + 16'($urandom_range(0, 120)) - 16'd60;
                    add_word(gdh_pkg::OP_LOAD, ox, oy, 9'($urandom), 9'($urandom));
                end else begin
                    add_word(gdh_pkg::OP_LOAD, 16'($urandom), 16'($urandom), 9'($urandom),
                             9'($urandom));
                end
                if ($urandom_range(0, 9) == 0) add_word(OP_NONE, 16'($urandom), 16'($urandom));
            end
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
                if ($urandom_range(0, 1)) add_render(hx + 9'($urandom_range(0, 2)) - 9'd1,
                                                     hy + 9'($urandom_range(0, 2)) - 9'd1);
                else add_render(9'($urandom), 9'($urandom));
            end
            while (word_q.size() > 20) @(posedge i_clk);
        end

        while (word_q.size() > 0 || i_in_valid || level_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("renders %0d (%0d on a full store, %0d marker hits), loads %0d, results %0d",
                 n_render, n_full, n_hit, n_load, n_out);
        if (errors == 0 && level_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, level_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
